### design/kwm_pkg.sv
// Shared constants and types for the k-way sorted run merge.
package kwm_pkg;

    localparam int DEF_WAYS   = 8;
    localparam int VAL_W      = 32;
    localparam int WAY_W      = 3;
    localparam int CFG_W      = 4;
    localparam int ADDR_WAYS  = 8;
    localparam int CFG_RESET  = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_PUSH
    } t_state;

endpackage

### design/kwm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/k_way_sorted_run_merge.sv
// Top level of the k-way sorted run merge: head memory, flags and scan sequencer.
// An accepted beat is applied to the head flags, and the emit condition is then checked in ST_CHECK.
// Each emitted result needs a scan of the head memory over the active runs at one read
// per cycle, a load into the output register once the output is free, and a recheck.
// A new input beat is taken once the sequencer is idle, even while a result waits.
// Synchronous active-low reset clears all flags, the sequencer and the output valid.
module k_way_sorted_run_merge
    import kwm_pkg::*;
#(
    parameter int WAYS = DEF_WAYS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [WAY_W-1:0]        i_way,
    input  logic signed [VAL_W-1:0] i_element,
    input  logic                    i_carries_value,
    input  logic                    i_run_ends,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_merged_value,
    output logic [WAY_W-1:0]        o_source_way,
    output logic                    o_has_value,
    output logic                    o_merge_done
);

    localparam int LIM = (WAYS < ADDR_WAYS) ? WAYS : ADDR_WAYS;
    localparam int IW  = $clog2(LIM);
    localparam int AW  = $clog2(WAYS);

    t_state r_state, n_state;
    logic [LIM-1:0]   r_full, n_full;
    logic [LIM-1:0]   r_fin, n_fin;
    logic [CFG_W-1:0] r_cfg;
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_issuing, n_issuing;
    logic             r_pend, n_pend;
    logic [IW-1:0]    r_pend_idx, n_pend_idx;
    logic             r_best_any, n_best_any;
    logic signed [VAL_W-1:0] r_best_val, n_best_val;
    logic [IW-1:0]    r_best_idx, n_best_idx;
    logic             r_term, n_term;
    logic             r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0] r_out_val, n_out_val;
    logic [WAY_W-1:0] r_out_way, n_out_way;
    logic             r_out_hv, n_out_hv;
    logic             r_out_done, n_out_done;

    logic [CFG_W-1:0] n_eff;
    logic [LIM-1:0]   act;
    logic [LIM-1:0]   best_oh;
    logic             in_acc;
    logic             way_ok;
    logic [IW-1:0]    way_idx;
    logic             ram_we;
    logic             ram_re;
    logic signed [VAL_W-1:0] ram_rdata;
    logic             ready;
    logic             any_full;
    logic             last_emit;
    logic             out_free;
    logic             take;

    always_comb begin
        if (r_cfg == '0) begin
            n_eff = CFG_W'(1);
        end else if (r_cfg > CFG_W'(LIM)) begin
            n_eff = CFG_W'(LIM);
        end else begin
            n_eff = r_cfg;
        end
        for (int i = 0; i < LIM; i++) begin
            act[i] = (CFG_W'(i) < n_eff);
        end
    end

    assign in_acc    = i_in_valid && !o_in_stall;
    assign way_idx   = IW'(i_way);
    assign way_ok    = ({1'b0, i_way} < n_eff) && !r_fin[way_idx];
    assign ram_we    = in_acc && way_ok && i_carries_value && !r_full[way_idx];
    assign ram_re    = (r_state == ST_SCAN) && r_issuing;
    assign ready     = &(r_full | r_fin | ~act);
    assign any_full  = |(r_full & act);
    assign best_oh   = LIM'(1) << r_best_idx;
    assign last_emit = ((r_full & act & ~best_oh) == '0) && (&(r_fin | ~act));
    assign out_free  = !r_out_valid || !i_out_stall;

    kwm_ram #(
        .WIDTH(VAL_W),
        .DEPTH(WAYS)
    ) u_head_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(AW'(i_way)),
        .i_wdata(i_element),
        .i_re   (ram_re),
        .i_raddr(AW'(r_idx)),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_full      = r_full;
        n_fin       = r_fin;
        n_idx       = r_idx;
        n_issuing   = r_issuing;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_best_any  = r_best_any;
        n_best_val  = r_best_val;
        n_best_idx  = r_best_idx;
        n_term      = r_term;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_val   = r_out_val;
        n_out_way   = r_out_way;
        n_out_hv    = r_out_hv;
        n_out_done  = r_out_done;
        take        = 1'b0;
        o_in_stall  = (r_state != ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (way_ok) begin
                        if (i_carries_value) begin
                            n_full[way_idx] = 1'b1;
                        end
                        if (i_run_ends) begin
                            n_fin[way_idx] = 1'b1;
                        end
                    end
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!ready) begin
                    n_state = ST_IDLE;
                end else if (!any_full) begin
                    n_term  = 1'b1;
                    n_state = ST_PUSH;
                end else begin
                    n_term     = 1'b0;
                    n_idx      = '0;
                    n_issuing  = 1'b1;
                    n_best_any = 1'b0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_issuing) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                    if (CFG_W'(r_idx) == n_eff - CFG_W'(1)) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
                if (r_pend) begin
                    take = r_full[r_pend_idx] && (!r_best_any || (ram_rdata < r_best_val));
                    if (take) begin
                        n_best_any = 1'b1;
                        n_best_val = ram_rdata;
                        n_best_idx = r_pend_idx;
                    end
                    if (CFG_W'(r_pend_idx) == n_eff - CFG_W'(1)) begin
                        n_state = ST_PUSH;
                    end
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_term) begin
                        n_out_val  = '0;
                        n_out_way  = '0;
                        n_out_hv   = 1'b0;
                        n_out_done = 1'b1;
                    end else begin
                        n_out_val  = r_best_val;
                        n_out_way  = WAY_W'(r_best_idx);
                        n_out_hv   = 1'b1;
                        n_out_done = last_emit;
                    end
                    if (r_term || last_emit) begin
                        n_full  = '0;
                        n_fin   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_full[r_best_idx] = 1'b0;
                        n_state = ST_CHECK;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_full      <= '0;
            r_fin       <= '0;
            r_cfg       <= CFG_W'(CFG_RESET);
            r_issuing   <= 1'b0;
            r_pend      <= 1'b0;
            r_best_any  <= 1'b0;
            r_term      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_full      <= n_full;
            r_fin       <= n_fin;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_issuing   <= n_issuing;
            r_pend      <= n_pend;
            r_best_any  <= n_best_any;
            r_term      <= n_term;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_out_val  <= n_out_val;
        r_out_way  <= n_out_way;
        r_out_hv   <= n_out_hv;
        r_out_done <= n_out_done;
    end

    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_out_val;
    assign o_source_way   = r_out_way;
    assign o_has_value    = r_out_hv;
    assign o_merge_done   = r_out_done;

    a_empty_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_value |-> o_merge_done)
        else $error("empty result beat without merge_done");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH) && out_free && (r_term || last_emit)
        |=> (r_full == '0) && (r_fin == '0))
        else $error("flags not cleared at merge end");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && r_issuing |-> (CFG_W'(r_idx) < n_eff))
        else $error("head scan beyond active runs");

    a_push_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH) && !r_term |-> r_best_any && r_full[r_best_idx])
        else $error("emitting a head that is not held");

endmodule
